### src/ssmt_pkg.sv
// Shared types and codes for the scanline span merge table.
`default_nettype none

package ssmt_pkg;

	// Width of every coordinate and row field on the item channel.
	localparam int IN_BITS = 12;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_QUERY  = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef logic signed [IN_BITS-1:0] coord_in_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
		logic sweep;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_clear;
		logic sweep_last;
		logic out_busy;
	} ctrl_stat_t;

endpackage

`default_nettype wire

### src/ssmt_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface ssmt_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	ssmt_pkg::coord_in_t row;
	ssmt_pkg::coord_in_t span_left;
	ssmt_pkg::coord_in_t span_right;
	ssmt_pkg::coord_in_t point_x;

	modport source (output valid, func, row, span_left, span_right, point_x, input ready);
	modport sink (input valid, func, row, span_left, span_right, point_x, output ready);
endinterface

interface ssmt_out_if;
	logic       valid;
	logic       ready;
	logic       visible;
	logic [1:0] status;

	modport source (output valid, visible, status, input ready);
	modport sink (input valid, visible, status, output ready);
endinterface

`default_nettype wire

### src/ssmt_ctrl.sv
// Controller state machine: sequences capture, evaluation and clearing sweeps.
`default_nettype none

module ssmt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ssmt_pkg::ctrl_stat_t stat,
	output ssmt_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EVAL  = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		cmd.sweep   = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = stat.req_clear ? ST_CLEAR : ST_EVAL;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/ssmt_datapath.sv
// Datapath: row memories, parallel span compare and merge, result register.
`default_nettype none

module ssmt_datapath #(
	parameter int ROWS          = 1024,
	parameter int SPANS_PER_ROW = 8,
	parameter int COORD_BITS    = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ssmt_pkg::ctrl_cmd_t  cmd,
	output ssmt_pkg::ctrl_stat_t      stat,
	input  wire logic [1:0]           func,
	input  wire ssmt_pkg::coord_in_t  row,
	input  wire ssmt_pkg::coord_in_t  span_left,
	input  wire ssmt_pkg::coord_in_t  span_right,
	input  wire ssmt_pkg::coord_in_t  point_x,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      visible,
	output logic [1:0]                status
);

	localparam int IN_BITS = ssmt_pkg::IN_BITS;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W   = $clog2(SPANS_PER_ROW + 1);
	localparam int SLOT_W  = 2 * COORD_BITS;
	localparam int WORD_W  = SPANS_PER_ROW * SLOT_W;
	localparam int CMP_W   = (COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS;

	// One word per row holds all its spans; a second memory holds the fill counts.
	logic [WORD_W-1:0] span_mem [ROWS];
	logic [CNT_W-1:0]  cnt_mem  [ROWS];

	logic [WORD_W-1:0]         word_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [1:0]                func_q;
	logic [ROW_AW-1:0]         addr_q;
	logic                      row_ok_q;
	ssmt_pkg::coord_in_t       a_q;
	ssmt_pkg::coord_in_t       b_q;
	ssmt_pkg::coord_in_t       x_q;
	logic [ROW_AW-1:0]         sweep_q;
	logic                      out_valid_q;
	logic                      visible_q;
	ssmt_pkg::status_t         status_q;

	logic                      row_ok;
	logic [ROW_AW-1:0]         row_addr;
	logic [CNT_W-1:0]          cnt_n;
	logic                      full;
	logic [SPANS_PER_ROW-1:0]  any_hit;
	logic [SPANS_PER_ROW-1:0]  first_oh;
	logic [SPANS_PER_ROW-1:0]  in_span;
	logic                      hit;
	logic [WORD_W-1:0]         word_new;
	logic signed [CMP_W-1:0]   a_x;
	logic signed [CMP_W-1:0]   b_x;
	logic signed [CMP_W-1:0]   x_x;
	logic signed [COORD_BITS-1:0] a_fit;
	logic signed [COORD_BITS-1:0] b_fit;
	logic                      is_insert;
	logic                      span_we;
	logic                      cnt_we;
	logic                      visible_c;
	ssmt_pkg::status_t         status_c;

	// Row range check on the incoming word.
	assign row_ok   = !row[IN_BITS-1] && ({1'b0, row} < (IN_BITS + 1)'(ROWS));
	assign row_addr = row[ROW_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q   <= span_mem[row_addr];
			cnt_q    <= cnt_mem[row_addr];
			func_q   <= func;
			addr_q   <= row_addr;
			row_ok_q <= row_ok;
			a_q      <= span_left;
			b_q      <= span_right;
			x_q      <= point_x;
		end
	end

	assign cnt_n = (cnt_q > CNT_W'(SPANS_PER_ROW)) ? CNT_W'(SPANS_PER_ROW) : cnt_q;
	assign full  = (cnt_n == CNT_W'(SPANS_PER_ROW));
	assign a_x   = CMP_W'(a_q);
	assign b_x   = CMP_W'(b_q);
	assign x_x   = CMP_W'(x_q);
	assign a_fit = COORD_BITS'(a_q);
	assign b_fit = COORD_BITS'(b_q);

	assign first_oh = any_hit & (~any_hit + SPANS_PER_ROW'(1));
	assign hit      = |any_hit;

	for (genvar i = 0; i < SPANS_PER_ROW; i++) begin : g_slot
		logic signed [COORD_BITS-1:0] s_c;
		logic signed [COORD_BITS-1:0] e_c;
		logic signed [CMP_W-1:0]      s_x;
		logic signed [CMP_W-1:0]      e_x;
		logic                         vld;
		logic                         m_right;
		logic                         m_left;
		logic                         m_inner;
		logic                         app;
		logic signed [COORD_BITS-1:0] s_new;
		logic signed [COORD_BITS-1:0] e_new;

		assign s_c = word_q[i*SLOT_W +: COORD_BITS];
		assign e_c = word_q[i*SLOT_W + COORD_BITS +: COORD_BITS];
		assign s_x = CMP_W'(s_c);
		assign e_x = CMP_W'(e_c);
		assign vld = (CNT_W'(i) < cnt_n);

		assign m_right = vld && (s_x <= b_x) && (b_x <= e_x);
		assign m_left  = vld && (s_x <= a_x) && (a_x <= e_x);
		assign m_inner = vld && (a_x < s_x) && (e_x < b_x);
		assign any_hit[i] = m_right || m_left || m_inner;
		assign in_span[i] = vld && (x_x >= s_x) && (x_x < e_x);
		assign app = !hit && !full && (cnt_n == CNT_W'(i));

		always_comb begin
			s_new = s_c;
			e_new = e_c;
			if (first_oh[i]) begin
				if (m_right) begin
					if (a_x < s_x) begin
						s_new = a_fit;
					end
				end else if (m_left) begin
					if (b_x > e_x) begin
						e_new = b_fit;
					end
				end else begin
					s_new = a_fit;
					e_new = b_fit;
				end
			end else if (app) begin
				s_new = a_fit;
				e_new = b_fit;
			end
		end

		assign word_new[i*SLOT_W +: SLOT_W] = {e_new, s_new};
	end

	assign is_insert = (func_q == ssmt_pkg::FUNC_INSERT);
	assign span_we   = cmd.commit && is_insert && row_ok_q && (hit || !full);
	assign cnt_we    = cmd.commit && is_insert && row_ok_q && !hit && !full;
	assign visible_c = (func_q == ssmt_pkg::FUNC_QUERY) && row_ok_q && (|in_span);

	always_comb begin
		status_c = ssmt_pkg::STATUS_OK;
		if (is_insert) begin
			if (!row_ok_q) begin
				status_c = ssmt_pkg::STATUS_RANGE;
			end else if (!hit && full) begin
				status_c = ssmt_pkg::STATUS_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (span_we) begin
			span_mem[addr_q] <= word_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			cnt_mem[sweep_q] <= '0;
		end else if (cnt_we) begin
			cnt_mem[addr_q] <= cnt_n + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= stat.sweep_last ? '0 : sweep_q + ROW_AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			visible_q <= visible_c;
			status_q  <= status_c;
		end
	end

	assign stat.req_clear  = (func == ssmt_pkg::FUNC_CLEAR);
	assign stat.sweep_last = (sweep_q == ROW_AW'(ROWS - 1));
	assign stat.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign visible   = visible_q;
	assign status    = status_q;

endmodule

`default_nettype wire

### src/scanline_span_merge_table.sv
// Top level of the scanline span merge table: per-row span store with merge and query.
// Insert, query and the unused code: one memory read, then one evaluate that registers the result;
// evaluate waits while the last result is stalled, and no new request is taken until it is done.
// Clear all rows: a sweep over the count memory, then the evaluate step that registers the result.
// After reset a sweep zeroes every row count; no request is taken until it ends.
`default_nettype none

module scanline_span_merge_table #(
	parameter int ROWS          = 1024,
	parameter int SPANS_PER_ROW = 8,
	parameter int COORD_BITS    = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssmt_in_if.sink    req,
	ssmt_out_if.source rsp
);

	// The controller only sequences the work; all storage, the parallel compare of a
	// row's spans and the result register live in the datapath.  Each request word
	// reads its row's span word and fill count in the cycle it is taken, and the
	// evaluate state compares every slot against the new span, picks the first slot
	// that matches in insertion order and, for an insert, writes the merged row word back.
	ssmt_pkg::ctrl_cmd_t  cmd;
	ssmt_pkg::ctrl_stat_t stat;

	ssmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The result register lets a new request word be taken while the previous result
	// word still waits on the response channel.
	ssmt_datapath #(
		.ROWS          (ROWS),
		.SPANS_PER_ROW (SPANS_PER_ROW),
		.COORD_BITS    (COORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (req.func),
		.row        (req.row),
		.span_left  (req.span_left),
		.span_right (req.span_right),
		.point_x    (req.point_x),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.visible    (rsp.visible),
		.status     (rsp.status)
	);

endmodule

`default_nettype wire

### src/ssmt_checker.sv
// Port-level checker for the span merge table and its bind to the top level.
`default_nettype none

module ssmt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic [1:0] req_func,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       rsp_visible,
	input wire logic [1:0] rsp_status
);

	// One request at a time: ready drops after a word is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
	else $error("request taken while previous one still in progress");

	// Anything but a clear leaves a result word on offer after its evaluate state:
	// its own result, or the earlier one that is still waiting for the receiver.
	a_prompt_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_func != ssmt_pkg::FUNC_CLEAR) |=> ##1 rsp_valid)
	else $error("no result word after a non-clear request");

	// A visible point only comes from a query, whose status is always ok.
	a_visible_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_visible && rsp_status != ssmt_pkg::STATUS_OK))
	else $error("visible result with non-ok status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_visible) && $stable(rsp_status))
	else $error("stalled result word changed or dropped");

endmodule

bind scanline_span_merge_table ssmt_checker u_ssmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_func    (req.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_visible (rsp.visible),
	.rsp_status  (rsp.status)
);

`default_nettype wire

### dv/tb_scanline_span_merge_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scanline span merge table: a directed table, then random words.
module tb_scanline_span_merge_table;

	// The block is built with its default sizes; the predictor uses the same ones.
	localparam int ROWS          = 1024;
	localparam int SPANS_PER_ROW = 8;
	localparam int COORD_BITS    = 12;

	// The fourth selector has no operation behind it, so the package leaves it unnamed.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 1080;
	localparam int CALM_TAIL    = 150;  // final random words sent with no idling at all
	localparam int HOLD_AFTER   = 300;  // result words taken before the long hold-off
	localparam int LONG_HOLD    = 300;  // cycles the receiver then holds ready low
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP    = 40;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One request word, laid out as the channel carries it.
	typedef struct packed {
		logic [1:0]          func;
		ssmt_pkg::coord_in_t row;
		ssmt_pkg::coord_in_t span_left;
		ssmt_pkg::coord_in_t span_right;
		ssmt_pkg::coord_in_t point_x;
	} span_word_t;

	// One awaited response word, tagged with the number of the request that caused it.
	typedef struct packed {
		int unsigned       seq;
		logic              visible;
		ssmt_pkg::status_t status;
	} span_result_t;

	// A line of the directed table. Where fixed is set, vis and st are the result that is
	// plain from the operation alone; elsewhere the predictor supplies the result.
	typedef struct {
		logic [1:0]        func;
		int                row;
		int                lo;
		int                hi;
		int                px;
		bit                fixed;
		bit                vis;
		ssmt_pkg::status_t st;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ssmt_in_if  req ();
	ssmt_out_if rsp ();

	scanline_span_merge_table #(
		.ROWS         (ROWS),
		.SPANS_PER_ROW(SPANS_PER_ROW),
		.COORD_BITS   (COORD_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	// The testbench's own copy of the span table. Entries above a row's count are never read,
	// so they need no reset.
	coord_t     tab_start [ROWS][SPANS_PER_ROW];
	coord_t     tab_end   [ROWS][SPANS_PER_ROW];
	logic [3:0] tab_count [ROWS] = '{default: 4'd0};

	span_result_t due_results [$];

	// Fixed expectation travelling alongside the request word; driven like the payload, so
	// the scoreboard sees the value that belongs to the word it has just taken.
	logic              fixed_en     = 1'b0;
	logic              fixed_vis    = 1'b0;
	ssmt_pkg::status_t fixed_status = ssmt_pkg::STATUS_OK;

	bit idle_on   = 1'b1;
	bit hold_done = 1'b0;

	int unsigned words_sent    = 0;
	int unsigned words_taken   = 0;
	int unsigned results_taken = 0;
	int unsigned mismatches    = 0;
	int unsigned n_insert = 0, n_query = 0, n_clear = 0, n_unused = 0;
	int unsigned n_full = 0, n_range = 0, n_visible = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Applies one request word to the table copy and returns the response word it must cause.
	// Insert walks the row in insertion order and stops at the first span that takes the new
	// one: the new right end inside it lowers its start, else the new left end inside it
	// raises its end, else a span lying strictly inside the new one is replaced. Spans that the
	// new one bridges stay apart. A query is half-open on the right.
	function automatic span_result_t merge_and_probe(input span_word_t w);
		span_result_t r;
		int           y, a, b, x, n, s, e;
		bit           hit;
		r.seq     = 0;
		r.visible = 1'b0;
		r.status  = ssmt_pkg::STATUS_OK;
		y   = $signed(w.row);
		a   = $signed(w.span_left);
		b   = $signed(w.span_right);
		x   = $signed(w.point_x);
		hit = 1'b0;
		if (w.func == ssmt_pkg::FUNC_INSERT) begin
			if (y < 0 || y >= ROWS) begin
				r.status = ssmt_pkg::STATUS_RANGE;
			end else begin
				n = tab_count[y];
				for (int i = 0; i < n && !hit; i++) begin
					s = tab_start[y][i];
					e = tab_end[y][i];
					if (s <= b && b <= e) begin
						if (a < s)
							tab_start[y][i] = coord_t'(a);
						hit = 1'b1;
					end else if (s <= a && a <= e) begin
						if (b > e)
							tab_end[y][i] = coord_t'(b);
						hit = 1'b1;
					end else if (a < s && e < b) begin
						tab_start[y][i] = coord_t'(a);
						tab_end[y][i]   = coord_t'(b);
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (n >= SPANS_PER_ROW) begin
						r.status = ssmt_pkg::STATUS_FULL;
					end else begin
						tab_start[y][n] = coord_t'(a);
						tab_end[y][n]   = coord_t'(b);
						tab_count[y]    = 4'(n + 1);
					end
				end
			end
		end else if (w.func == ssmt_pkg::FUNC_QUERY) begin
			if (y >= 0 && y < ROWS) begin
				for (int i = 0; i < int'(tab_count[y]); i++)
					if (x >= tab_start[y][i] && x < tab_end[y][i])
						r.visible = 1'b1;
			end
		end else if (w.func == ssmt_pkg::FUNC_CLEAR) begin
			foreach (tab_count[k])
				tab_count[k] = 4'd0;
		end
		return r;
	endfunction

	// Uniform column in [-half, half): narrow enough that spans overlap and merge often.
	function automatic int window_coord(input int half);
		return int'($urandom_range(0, 2 * half - 1)) - half;
	endfunction

	// Offers one word and returns at the edge where it is taken. While idling is on, valid may
	// first go low before the word is offered; valid is never lowered and raised within the same step.
	task automatic offer_word(input span_word_t w, input bit fixed, input bit vis,
			input ssmt_pkg::status_t st);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.func       <= w.func;
		req.row        <= w.row;
		req.span_left  <= w.span_left;
		req.span_right <= w.span_right;
		req.point_x    <= w.point_x;
		fixed_en       <= fixed;
		fixed_vis      <= vis;
		fixed_status   <= st;
		words_sent++;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	// Scoreboard. Both sides are sampled at the same edge, request side first, so a word and
	// its expectation are always queued before any response to it can be looked at.
	always @(posedge clk) begin : scoreboard
		span_word_t   taken;
		span_result_t want;
		if (arst_n && req.valid === 1'b1 && req.ready === 1'b1) begin
			taken = {req.func, req.row, req.span_left, req.span_right, req.point_x};
			want  = merge_and_probe(taken);
			if (fixed_en) begin
				want.visible = fixed_vis;
				want.status  = fixed_status;
			end
			want.seq = words_taken;
			due_results.push_back(want);
			words_taken++;
			case (taken.func)
				ssmt_pkg::FUNC_INSERT: n_insert++;
				ssmt_pkg::FUNC_QUERY:  n_query++;
				ssmt_pkg::FUNC_CLEAR:  n_clear++;
				default:               n_unused++;
			endcase
			if (want.status == ssmt_pkg::STATUS_FULL)
				n_full++;
			if (want.status == ssmt_pkg::STATUS_RANGE)
				n_range++;
			if (want.visible)
				n_visible++;
		end
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			results_taken++;
			if (due_results.size() == 0) begin
				report_mismatch("response word arrived with no request pending");
			end else begin
				want = due_results.pop_front();
				if (rsp.visible !== want.visible)
					report_mismatch($sformatf("word %0d: visible %b, expected %b",
						want.seq, rsp.visible, want.visible));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("word %0d: status %0d, expected %0d",
						want.seq, rsp.status, want.status));
			end
		end
	end

	// Receiver. Ready drops in short bursts while idling is on, and once, after a few hundred
	// responses, stays low for a long stretch so that the block backs up and stops taking
	// request words while the sender keeps offering them.
	initial begin : response_side
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && !hold_done && results_taken >= HOLD_AFTER) begin
				rsp.ready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++)
					@(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : request_side
		span_word_t    w;
		directed_row_t d;
		directed_row_t directed [$];
		int            sel, lo, hi;

		req.valid      <= 1'b0;
		req.func       <= ssmt_pkg::FUNC_INSERT;
		req.row        <= '0;
		req.span_left  <= '0;
		req.span_right <= '0;
		req.point_x    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. Row 0 is built up span by span: a fresh span, its start lowered,
		// its end raised, a span swallowed by a wider one, two spans bridged without being
		// merged, then filled to the last slot so that one more insert is dropped.
		// Fields: func, row, left, right, point, then fixed, visible, status.
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  0,     0,    0,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,    10,   20,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  0,     0,    0,   10,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  0,     0,    0,   20,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,     5,   12,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,    18,   30,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,     0,   40,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,    50,   60,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,    70,   80,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,    55,   75,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   100,  110,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   120,  130,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   140,  150,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   160,  170,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   180,  190,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 0,   200,  210,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_FULL});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  0,     0,    0,   77,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		// Rows outside the table, on both sides, and the selector with no operation.
		directed.push_back('{ssmt_pkg::FUNC_INSERT, -1,    0,   10,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_RANGE});
		directed.push_back('{ssmt_pkg::FUNC_INSERT, ROWS,  0,   10,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_RANGE});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  -2048, 0,    0,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{FUNC_UNUSED,           0,     0,   10,    5,
			1'b1, 1'b0, ssmt_pkg::STATUS_OK});
		// Widest possible span on the last row, probed at both ends of the column range.
		directed.push_back('{ssmt_pkg::FUNC_INSERT, ROWS - 1, -2048, 2047, 0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  ROWS - 1, 0, 0, -2048,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  ROWS - 1, 0, 0,  2047,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		// An inverted span is kept as given; after a clear nothing is visible.
		directed.push_back('{ssmt_pkg::FUNC_INSERT, 1,    30,   10,    0,
			1'b0, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_CLEAR,  0,     0,    0,    0,
			1'b1, 1'b0, ssmt_pkg::STATUS_OK});
		directed.push_back('{ssmt_pkg::FUNC_QUERY,  0,     0,    0,    5,
			1'b1, 1'b0, ssmt_pkg::STATUS_OK});

		foreach (directed[i]) begin
			d = directed[i];
			w.func       = d.func;
			w.row        = ssmt_pkg::coord_in_t'(d.row);
			w.span_left  = ssmt_pkg::coord_in_t'(d.lo);
			w.span_right = ssmt_pkg::coord_in_t'(d.hi);
			w.point_x    = ssmt_pkg::coord_in_t'(d.px);
			offer_word(w, d.fixed, d.vis, d.st);
		end

		// Random part. Most words land on a handful of rows with columns in a narrow window,
		// so spans merge, rows fill up and queries hit; clears are rare so that rows have
		// time to fill between them. The rest spreads over every row, out-of-range rows,
		// the full column range, inverted spans and words with every field random.
		// Idling alternates on and off every hundred words and stops for the final stretch.
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			idle_on = (k < RANDOM_WORDS - CALM_TAIL) && ((k / 100) % 2 == 0);

			sel = $urandom_range(0, 99);
			if (sel < 75)
				w.row = ($urandom_range(0, 2) == 2)
					? ssmt_pkg::coord_in_t'(ROWS - 1)
					: ssmt_pkg::coord_in_t'($urandom_range(0, 1));
			else if (sel < 90)
				w.row = ssmt_pkg::coord_in_t'($urandom_range(0, ROWS - 1));
			else if (sel < 95)
				w.row = ssmt_pkg::coord_in_t'(-int'($urandom_range(1, 2048)));
			else
				w.row = ssmt_pkg::coord_in_t'($urandom_range(ROWS, 2047));

			sel = $urandom_range(0, 99);
			lo  = window_coord(128);
			if (sel < 85) begin
				hi = lo + int'($urandom_range(1, 10));
			end else if (sel < 92) begin
				hi = lo - int'($urandom_range(0, 8));
			end else begin
				lo = int'(ssmt_pkg::coord_in_t'($urandom));
				hi = int'(ssmt_pkg::coord_in_t'($urandom));
			end
			w.span_left  = ssmt_pkg::coord_in_t'(lo);
			w.span_right = ssmt_pkg::coord_in_t'(hi);
			w.point_x    = ($urandom_range(0, 99) < 85)
				? ssmt_pkg::coord_in_t'(window_coord(140))
				: ssmt_pkg::coord_in_t'($urandom);

			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				w.func = ssmt_pkg::FUNC_INSERT;
			end else if (sel < 95) begin
				w.func = ssmt_pkg::FUNC_QUERY;
			end else if (sel < 96) begin
				w.func = ssmt_pkg::FUNC_CLEAR;
			end else if (sel < 98) begin
				w.func = FUNC_UNUSED;
			end else begin
				// Noise: every field random.
				w.func       = 2'($urandom);
				w.row        = ssmt_pkg::coord_in_t'($urandom);
				w.span_left  = ssmt_pkg::coord_in_t'($urandom);
				w.span_right = ssmt_pkg::coord_in_t'($urandom);
				w.point_x    = ssmt_pkg::coord_in_t'($urandom);
			end
			offer_word(w, 1'b0, 1'b0, ssmt_pkg::STATUS_OK);
		end
		req.valid <= 1'b0;

		// Every word causes exactly one response, so once the last one is in, the block is idle.
		@(posedge clk);
		while (words_taken != words_sent || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d words: %0d inserts (%0d dropped on a full row, %0d on a bad row),",
			words_taken, n_insert, n_full, n_range);
		$display("%0d queries (%0d visible), %0d clears, %0d unused selectors; %0d mismatches.",
			n_query, n_visible, n_clear, n_unused, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Several times the longest run this stimulus can take, clears and the hold-off included.
	initial begin : watchdog
		#400000;
		$display("Timed out with %0d response words still pending.", due_results.size());
		$display("FAILURE");
		$finish;
	end

endmodule
